[rtl/pvpc_pkg.sv]
// Shared types, codes and constants for the vibration PWM pulse controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package pvpc_pkg;

  localparam int PWM_BITS_DEF  = 8;
  localparam int TIME_BITS_DEF = 32;
  localparam int DUTY_BITS     = 8;
  localparam int PCT_BITS      = 7;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_LEVEL  = 3'd1;
  localparam logic [2:0] OP_ON     = 3'd2;
  localparam logic [2:0] OP_OFF    = 3'd3;
  localparam logic [2:0] OP_TIMED  = 3'd4;
  localparam logic [2:0] OP_PULSE  = 3'd5;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_TIMED = 2'd1;
  localparam logic [1:0] MODE_PON   = 2'd2;
  localparam logic [1:0] MODE_POFF  = 2'd3;

  localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;
  localparam logic [7:0]          STRENGTH_MAX = 8'd100;
  localparam logic [7:0]          LEVEL_MAX = 8'd10;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for every x below 2^23
  localparam int                        DIV100_MUL_BITS = 24;
  localparam logic [DIV100_MUL_BITS-1:0] DIV100_MUL     = 24'd10737419;
  localparam int                        DIV100_SHIFT    = 30;

  localparam logic [PCT_BITS-1:0] LEVEL_PCT [0:10] = '{
    7'd0, 7'd25, 7'd33, 7'd41, 7'd50, 7'd58, 7'd66, 7'd75, 7'd83, 7'd91, 7'd100
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [7:0]  level;
    logic        use_strength;
    logic [7:0]  strength_percent;
    logic [31:0] duration_ms;
    logic [7:0]  pulse_count;
    logic [31:0] pulse_on_ms;
    logic [31:0] pulse_off_ms;
  } pvpc_in_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 active;
    logic [1:0]           mode_code;
  } pvpc_out_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic mul_pct;
    logic div_pct;
    logic mul_duty;
    logic div_duty;
    logic emit;
  } pvpc_cmd_t;

  typedef struct packed {
    logic wr_pending;
  } pvpc_sts_t;

  function automatic logic [PCT_BITS-1:0] level_to_pct(input logic [7:0] lv);
    logic [3:0] idx;
    idx = (lv > LEVEL_MAX) ? 4'd10 : lv[3:0];
    return LEVEL_PCT[idx];
  endfunction

endpackage

`default_nettype wire

[rtl/pvpc_ctrl.sv]
// Sequencer for the vibration PWM pulse controller: steps one item through
// decode, percent and duty arithmetic, and result hand-off. Uses pvpc_pkg.
`default_nettype none

module pvpc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pvpc_pkg::pvpc_cmd_t      cmd,
  input  wire pvpc_pkg::pvpc_sts_t sts
);
  import pvpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_PCT,
    S_DIV_PCT,
    S_MUL_DUTY,
    S_DIV_DUTY,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_MUL_PCT;
      end
      S_MUL_PCT: begin
        cmd.mul_pct = 1'b1;
        state_next  = sts.wr_pending ? S_DIV_PCT : S_EMIT;
      end
      S_DIV_PCT: begin
        cmd.div_pct = 1'b1;
        state_next  = S_MUL_DUTY;
      end
      S_MUL_DUTY: begin
        cmd.mul_duty = 1'b1;
        state_next   = S_DIV_DUTY;
      end
      S_DIV_DUTY: begin
        cmd.div_duty = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = !out_valid || !out_stall;
        if (cmd.emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/pvpc_datapath.sv]
// Datapath of the vibration PWM pulse controller: command decode, mode and
// timer state, percent and duty arithmetic, result register. Uses pvpc_pkg.
`default_nettype none

module pvpc_datapath #(
  parameter int PWM_BITS  = pvpc_pkg::PWM_BITS_DEF,
  parameter int TIME_BITS = pvpc_pkg::TIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire pvpc_pkg::pvpc_in_t  in_item,
  input  wire pvpc_pkg::pvpc_cmd_t cmd,
  output pvpc_pkg::pvpc_sts_t      sts,
  output pvpc_pkg::pvpc_out_t      out_item
);
  import pvpc_pkg::*;

  localparam int PP_W  = 2 * PCT_BITS;
  localparam int PQ_W  = PP_W + DIV100_MUL_BITS;
  localparam int DP_W  = PCT_BITS + PWM_BITS;
  localparam int DQ_W  = DP_W + DIV100_MUL_BITS;
  localparam int DX_W  = PWM_BITS + DUTY_BITS;
  localparam logic [PWM_BITS-1:0] PWM_MAX = '1;

  pvpc_in_t              item;
  logic                  active_high;
  logic [1:0]            mode;
  logic [TIME_BITS-1:0]  deadline;
  logic [7:0]            pulses_left;
  logic [TIME_BITS-1:0]  on_time;
  logic [TIME_BITS-1:0]  off_time;
  logic [PCT_BITS-1:0]   base_percent;
  logic [PCT_BITS-1:0]   command_percent;
  logic                  override_on;
  logic                  output_active;
  logic [PWM_BITS-1:0]   duty_now;
  logic                  wr_pending;
  logic                  en_pending;
  logic [PP_W-1:0]       pct_prod;
  logic [PCT_BITS-1:0]   eff;
  logic [DP_W-1:0]       duty_prod;

  logic [1:0]            mode_next;
  logic [TIME_BITS-1:0]  deadline_next;
  logic [7:0]            pulses_left_next;
  logic [TIME_BITS-1:0]  on_time_next;
  logic [TIME_BITS-1:0]  off_time_next;
  logic [PCT_BITS-1:0]   base_percent_next;
  logic [PCT_BITS-1:0]   command_percent_next;
  logic                  override_on_next;
  logic                  wr_next;
  logic                  en_next;

  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  dur_t;
  logic [TIME_BITS-1:0]  pon_t;
  logic [TIME_BITS-1:0]  poff_t;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  reached;
  logic [TIME_BITS-1:0]  addend;
  logic [TIME_BITS-1:0]  due;
  logic [7:0]            pulses_dec;
  logic [PCT_BITS-1:0]   strength_pct;
  logic [PQ_W-1:0]       pct_quot;
  logic [DQ_W-1:0]       duty_quot;
  logic [PWM_BITS-1:0]   duty_raw;
  logic [PWM_BITS-1:0]   duty_pol;
  logic [DX_W-1:0]       duty_ext;

  assign now_t   = item.now_ms[TIME_BITS-1:0];
  assign dur_t   = item.duration_ms[TIME_BITS-1:0];
  assign pon_t   = item.pulse_on_ms[TIME_BITS-1:0];
  assign poff_t  = item.pulse_off_ms[TIME_BITS-1:0];
  assign elapsed = now_t - deadline;
  assign reached = !elapsed[TIME_BITS-1];
  assign due     = now_t + addend;

  assign pulses_dec   = (pulses_left != 8'd0) ? pulses_left - 8'd1 : 8'd0;
  assign strength_pct = (item.strength_percent > STRENGTH_MAX) ? PCT_FULL
                                                             : item.strength_percent[6:0];

  always_comb begin
    mode_next            = mode;
    deadline_next        = deadline;
    pulses_left_next     = pulses_left;
    on_time_next         = on_time;
    off_time_next        = off_time;
    base_percent_next    = base_percent;
    command_percent_next = command_percent;
    override_on_next     = override_on;
    wr_next              = 1'b0;
    en_next              = 1'b0;
    addend               = on_time;

    unique case (item.opcode)
      OP_TICK: begin
        unique case (mode)
          MODE_TIMED: begin
            if (reached) begin
              override_on_next = 1'b0;
              mode_next        = MODE_IDLE;
              wr_next          = 1'b1;
            end
          end
          MODE_PON: begin
            addend = off_time;
            if (reached) begin
              wr_next       = 1'b1;
              mode_next     = MODE_POFF;
              deadline_next = due;
            end
          end
          MODE_POFF: begin
            if (reached) begin
              pulses_left_next = pulses_dec;
              wr_next          = 1'b1;
              if (pulses_dec == 8'd0) begin
                mode_next        = MODE_IDLE;
                override_on_next = 1'b0;
              end else begin
                en_next       = 1'b1;
                mode_next     = MODE_PON;
                deadline_next = due;
              end
            end
          end
          default: begin
          end
        endcase
      end
      OP_LEVEL: begin
        base_percent_next = level_to_pct(item.level);
        wr_next           = 1'b1;
        unique case (mode)
          MODE_POFF: en_next = 1'b0;
          MODE_IDLE: en_next = output_active;
          default:   en_next = 1'b1;
        endcase
      end
      OP_ON: begin
        override_on_next = item.use_strength;
        if (item.use_strength) command_percent_next = strength_pct;
        mode_next = MODE_IDLE;
        wr_next   = 1'b1;
        en_next   = 1'b1;
      end
      OP_OFF: begin
        override_on_next = 1'b0;
        mode_next        = MODE_IDLE;
        wr_next          = 1'b1;
      end
      OP_TIMED: begin
        addend  = dur_t;
        wr_next = 1'b1;
        if (dur_t == '0) begin
          override_on_next = 1'b0;
          mode_next        = MODE_IDLE;
        end else begin
          override_on_next = item.use_strength;
          if (item.use_strength) command_percent_next = strength_pct;
          en_next       = 1'b1;
          mode_next     = MODE_TIMED;
          deadline_next = due;
        end
      end
      OP_PULSE: begin
        addend  = pon_t;
        wr_next = 1'b1;
        if (item.pulse_count == 8'd0 || pon_t == '0) begin
          override_on_next = 1'b0;
          mode_next        = MODE_IDLE;
        end else begin
          override_on_next = item.use_strength;
          if (item.use_strength) command_percent_next = strength_pct;
          on_time_next     = pon_t;
          off_time_next    = poff_t;
          pulses_left_next = item.pulse_count;
          en_next          = 1'b1;
          mode_next        = MODE_PON;
          deadline_next    = due;
        end
      end
      default: begin
      end
    endcase
  end

  assign pct_quot  = PQ_W'(pct_prod) * PQ_W'(DIV100_MUL);
  assign duty_quot = DQ_W'(duty_prod) * DQ_W'(DIV100_MUL);
  assign duty_raw  = en_pending ? duty_quot[DIV100_SHIFT +: PWM_BITS] : '0;
  assign duty_pol  = active_high ? duty_raw : PWM_MAX - duty_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high     <= 1'b1;
      mode            <= MODE_IDLE;
      deadline        <= '0;
      pulses_left     <= 8'd0;
      on_time         <= '0;
      off_time        <= '0;
      base_percent    <= PCT_FULL;
      command_percent <= PCT_FULL;
      override_on     <= 1'b0;
      output_active   <= 1'b0;
      duty_now        <= '0;
      wr_pending      <= 1'b0;
      en_pending      <= 1'b0;
    end else begin
      if (cfg_we) active_high <= cfg_wdata;
      if (cmd.decode) begin
        mode            <= mode_next;
        deadline        <= deadline_next;
        pulses_left     <= pulses_left_next;
        on_time         <= on_time_next;
        off_time        <= off_time_next;
        base_percent    <= base_percent_next;
        command_percent <= command_percent_next;
        override_on     <= override_on_next;
        wr_pending      <= wr_next;
        en_pending      <= en_next;
      end
      if (cmd.div_duty && wr_pending) begin
        duty_now      <= duty_pol;
        output_active <= en_pending && (eff != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (cmd.mul_pct) pct_prod <= PP_W'(base_percent) * PP_W'(command_percent);
    if (cmd.div_pct) eff <= override_on ? pct_quot[DIV100_SHIFT +: PCT_BITS] : base_percent;
    if (cmd.mul_duty) duty_prod <= DP_W'(eff) * DP_W'(PWM_MAX);
    if (cmd.emit) begin
      out_item.duty      <= duty_ext[DUTY_BITS-1:0];
      out_item.active    <= output_active;
      out_item.mode_code <= mode;
    end
  end

  assign duty_ext       = DX_W'(duty_now);
  assign sts.wr_pending = wr_pending;

endmodule

`default_nettype wire

[rtl/pwm_vibration_pulse_controller.sv]
// An item is decoded, then runs the percent and duty multiply-by-reciprocal
// divide-by-100 passes on the shared sequencer and is emitted when the duty is
// rewritten; a command that leaves the duty alone goes from the percent multiply to
// emit. One item is in work at a time; none is taken until the last is emitted.
// Reset (rst, synchronous): mode idle, duty 0, inactive, percents 100, active_high 1.
`default_nettype none

module pwm_vibration_pulse_controller #(
  parameter int PWM_BITS  = pvpc_pkg::PWM_BITS_DEF,
  parameter int TIME_BITS = pvpc_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pvpc_pkg::pvpc_in_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pvpc_pkg::pvpc_out_t     out_item
);
  import pvpc_pkg::*;

  pvpc_cmd_t cmd;
  pvpc_sts_t sts;

  pvpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pvpc_datapath #(
    .PWM_BITS  (PWM_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[rtl/pvpc_checker.sv]
// Port-level checks for the vibration PWM pulse controller, bound to the top level.
// Uses pvpc_pkg.
`default_nettype none

module pvpc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pvpc_pkg::pvpc_out_t out_item
);
  import pvpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item still in work");

  a_poff_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.active && out_item.mode_code == MODE_POFF))
    else $error("output active during pulse off phase");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pwm_vibration_pulse_controller pvpc_checker u_pvpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
